FILE: rtl/lant_pkg.sv
// Langton's ant stepper: shared types, codes and the microcode program.
// Depends on nothing; used by langtons_ant_stepper_core.
package lant_pkg;

    localparam int GRID_SIDE_DEF = 64;
    localparam logic [5:0] START_RESET = 6'd32;

    // item opcodes
    localparam logic [1:0] OP_STEP    = 2'd0;
    localparam logic [1:0] OP_RESTART = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;

    // headings
    localparam logic [1:0] HEAD_NORTH = 2'd0;
    localparam logic [1:0] HEAD_EAST  = 2'd1;
    localparam logic [1:0] HEAD_SOUTH = 2'd2;
    localparam logic [1:0] HEAD_WEST  = 2'd3;

    // config register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ROW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_COL = 2'd1;

    typedef struct packed {
        logic [1:0] op;
        logic [5:0] read_row;
        logic [5:0] read_col;
    } t_in_word;

    typedef struct packed {
        logic [5:0] ant_row_out;
        logic [5:0] ant_col_out;
        logic [1:0] heading_out;
        logic       cell_value;
        logic       wrapped;
    } t_out_word;

    // microcode addresses
    localparam int UC_PC_W = 4;
    localparam logic [UC_PC_W-1:0] UC_IDLE        = 4'd0;
    localparam logic [UC_PC_W-1:0] UC_BOOT_CLR    = 4'd1;
    localparam logic [UC_PC_W-1:0] UC_STEP_RD     = 4'd2;
    localparam logic [UC_PC_W-1:0] UC_STEP_FLIP   = 4'd3;
    localparam logic [UC_PC_W-1:0] UC_STEP_RD_NEW = 4'd4;
    localparam logic [UC_PC_W-1:0] UC_STEP_TURN   = 4'd5;
    localparam logic [UC_PC_W-1:0] UC_RST_CLR     = 4'd6;
    localparam logic [UC_PC_W-1:0] UC_RST_LOAD    = 4'd7;
    localparam logic [UC_PC_W-1:0] UC_RD_ISSUE    = 4'd8;
    localparam logic [UC_PC_W-1:0] UC_RD_EMIT     = 4'd9;
    localparam logic [UC_PC_W-1:0] UC_NOP_EMIT    = 4'd10;

    typedef enum logic [2:0] {
        MEM_NONE,
        MEM_RD_ANT,
        MEM_RD_REQ,
        MEM_WR_FLIP,
        MEM_WR_CLR
    } t_mem_op;

    typedef enum logic [1:0] {
        CELL_ZERO,
        CELL_LEFT,
        CELL_RD
    } t_cell_sel;

    typedef enum logic [1:0] {
        JMP_GOTO,
        JMP_DISPATCH,
        JMP_CLR
    } t_jump;

    typedef struct packed {
        t_mem_op              mem;
        logic                 move;
        logic                 turn;
        logic                 load;
        logic                 emit;
        t_cell_sel            cell_sel;
        t_jump                jump;
        logic [UC_PC_W-1:0]   target;
    } t_uc_word;

    function automatic t_uc_word uc_rom(input logic [UC_PC_W-1:0] pc);
        t_uc_word w;
        w = '{mem: MEM_NONE, move: 1'b0, turn: 1'b0, load: 1'b0, emit: 1'b0,
              cell_sel: CELL_ZERO, jump: JMP_GOTO, target: UC_IDLE};
        unique case (pc)
            UC_IDLE: begin
                w.jump = JMP_DISPATCH;
            end
            UC_BOOT_CLR: begin
                w.mem  = MEM_WR_CLR;
                w.jump = JMP_CLR;
            end
            UC_STEP_RD: begin
                w.mem    = MEM_RD_ANT;
                w.target = UC_STEP_FLIP;
            end
            UC_STEP_FLIP: begin
                w.mem    = MEM_WR_FLIP;
                w.move   = 1'b1;
                w.target = UC_STEP_RD_NEW;
            end
            UC_STEP_RD_NEW: begin
                w.mem    = MEM_RD_ANT;
                w.target = UC_STEP_TURN;
            end
            UC_STEP_TURN: begin
                w.turn     = 1'b1;
                w.emit     = 1'b1;
                w.cell_sel = CELL_LEFT;
            end
            UC_RST_CLR: begin
                w.mem    = MEM_WR_CLR;
                w.jump   = JMP_CLR;
                w.target = UC_RST_LOAD;
            end
            UC_RST_LOAD: begin
                w.load = 1'b1;
                w.emit = 1'b1;
            end
            UC_RD_ISSUE: begin
                w.mem    = MEM_RD_REQ;
                w.target = UC_RD_EMIT;
            end
            UC_RD_EMIT: begin
                w.emit     = 1'b1;
                w.cell_sel = CELL_RD;
            end
            UC_NOP_EMIT: begin
                w.emit = 1'b1;
            end
            default: begin
                w.jump = JMP_DISPATCH;
            end
        endcase
        return w;
    endfunction

    function automatic logic [UC_PC_W-1:0] op_entry(input logic [1:0] op);
        logic [UC_PC_W-1:0] pc;
        unique case (op)
            OP_STEP:    pc = UC_STEP_RD;
            OP_RESTART: pc = UC_RST_CLR;
            OP_READ:    pc = UC_RD_ISSUE;
            default:    pc = UC_NOP_EMIT;
        endcase
        return pc;
    endfunction

    // 6-bit value modulo side; side >= 8 so seven subtracts always suffice
    function automatic logic [5:0] fold6(input logic [5:0] v, input int side);
        logic [5:0] r;
        r = v;
        for (int i = 0; i < 8; i++) begin
            if (int'(r) >= side) begin
                r = r - 6'(side);
            end
        end
        return r;
    endfunction

endpackage

FILE: rtl/langtons_ant_stepper_core.sv
// Langton's ant stepper top level: microcoded sequencer, cell memory, ant registers.
// Depends on lant_pkg (types, opcodes, microcode ROM).
// Items are taken one at a time: input stalls until the current item's result is issued;
// the pace is set by the single-port cell memory (step = read, flip-write, read)
// and by the restart clearing sweep.
// Reset: synchronous active low; ant at start 32/32 heading north, then a clearing
// pass over all GRID_SIDE^2 cells (4096 at the default) with input stalled.
module langtons_ant_stepper_core #(
    parameter int GRID_SIDE = lant_pkg::GRID_SIDE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // item input
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  lant_pkg::t_in_word            i_in_word,
    // result output
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output lant_pkg::t_out_word           o_out_word,
    // configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lant_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [5:0]                    i_cfg_data
);

    localparam int CW    = $clog2(GRID_SIDE);
    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(CELLS);

    // ---------------------------------------------------------------
    // Sequencer state
    // ---------------------------------------------------------------
    logic [lant_pkg::UC_PC_W-1:0] r_pc, n_pc;
    lant_pkg::t_uc_word           cw;
    logic                         step_go;   // current control word may execute
    logic                         in_accept;

    // ant and datapath registers
    logic [CW-1:0] r_ant_row, n_ant_row;
    logic [CW-1:0] r_ant_col, n_ant_col;
    logic [1:0]    r_heading, n_heading;
    logic          r_wrap, n_wrap;
    logic [CW-1:0] r_req_row, r_req_col;
    logic [5:0]    r_start_row, r_start_col;
    logic          r_left;       // colour left behind by the flip
    logic          r_rd_data;    // registered memory read
    logic [AW-1:0] r_clr_addr;
    logic          clr_last;

    // output register
    logic                r_out_valid;
    lant_pkg::t_out_word r_out_word;
    lant_pkg::t_out_word n_out_word;

    // cell memory: one bit per cell, one access per cycle
    logic          r_cells [CELLS];
    logic [AW-1:0] mem_addr;
    logic          mem_we, mem_wdata, mem_re;

    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] row,
                                                input logic [CW-1:0] col);
        return AW'(row) * AW'(GRID_SIDE) + AW'(col);
    endfunction

    assign cw        = lant_pkg::uc_rom(r_pc);
    assign o_in_stall = (r_pc != lant_pkg::UC_IDLE);
    assign in_accept = i_in_valid && !o_in_stall;
    // a result step waits while the output register is full and stalled
    assign step_go   = !(cw.emit && r_out_valid && i_out_stall);
    assign clr_last  = (r_clr_addr == AW'(CELLS - 1));
    assign o_cfg_ready = 1'b1;

    // ---------------------------------------------------------------
    // Next program counter
    // ---------------------------------------------------------------
    always_comb begin
        n_pc = r_pc;
        if (step_go) begin
            unique case (cw.jump)
                lant_pkg::JMP_DISPATCH: begin
                    n_pc = in_accept ? lant_pkg::op_entry(i_in_word.op) : lant_pkg::UC_IDLE;
                end
                lant_pkg::JMP_CLR: begin
                    n_pc = clr_last ? cw.target : r_pc;
                end
                default: begin
                    n_pc = cw.target;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Memory port control
    // ---------------------------------------------------------------
    always_comb begin
        mem_addr  = cell_addr(r_ant_row, r_ant_col);
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_wdata = 1'b0;
        unique case (cw.mem)
            lant_pkg::MEM_RD_ANT: begin
                mem_re = step_go;
            end
            lant_pkg::MEM_RD_REQ: begin
                mem_addr = cell_addr(r_req_row, r_req_col);
                mem_re   = step_go;
            end
            lant_pkg::MEM_WR_FLIP: begin
                mem_we    = step_go;
                mem_wdata = ~r_rd_data;
            end
            lant_pkg::MEM_WR_CLR: begin
                mem_addr = r_clr_addr;
                mem_we   = step_go;
            end
            default: begin
                mem_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_cells[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_cells[mem_addr];
        end
    end

    // ---------------------------------------------------------------
    // Ant datapath: move with wrap, turn on the new cell, restart load
    // ---------------------------------------------------------------
    always_comb begin
        n_ant_row = r_ant_row;
        n_ant_col = r_ant_col;
        n_heading = r_heading;
        n_wrap    = r_wrap;
        if (in_accept) begin
            n_wrap = 1'b0;
        end
        if (step_go && cw.move) begin
            unique case (r_heading)
                lant_pkg::HEAD_NORTH: begin
                    if (r_ant_row == '0) begin
                        n_ant_row = CW'(GRID_SIDE - 1);
                        n_wrap    = 1'b1;
                    end else begin
                        n_ant_row = r_ant_row - 1'b1;
                    end
                end
                lant_pkg::HEAD_EAST: begin
                    if (r_ant_col == CW'(GRID_SIDE - 1)) begin
                        n_ant_col = '0;
                        n_wrap    = 1'b1;
                    end else begin
                        n_ant_col = r_ant_col + 1'b1;
                    end
                end
                lant_pkg::HEAD_SOUTH: begin
                    if (r_ant_row == CW'(GRID_SIDE - 1)) begin
                        n_ant_row = '0;
                        n_wrap    = 1'b1;
                    end else begin
                        n_ant_row = r_ant_row + 1'b1;
                    end
                end
                default: begin
                    if (r_ant_col == '0) begin
                        n_ant_col = CW'(GRID_SIDE - 1);
                        n_wrap    = 1'b1;
                    end else begin
                        n_ant_col = r_ant_col - 1'b1;
                    end
                end
            endcase
        end
        // white turns right, black turns left
        if (step_go && cw.turn) begin
            n_heading = r_rd_data ? (r_heading + 2'd3) : (r_heading + 2'd1);
        end
        if (step_go && cw.load) begin
            n_ant_row = CW'(lant_pkg::fold6(r_start_row, GRID_SIDE));
            n_ant_col = CW'(lant_pkg::fold6(r_start_col, GRID_SIDE));
            n_heading = lant_pkg::HEAD_NORTH;
        end
    end

    // result word built from the post-item ant state
    always_comb begin
        n_out_word.ant_row_out = 6'(n_ant_row);
        n_out_word.ant_col_out = 6'(n_ant_col);
        n_out_word.heading_out = n_heading;
        n_out_word.wrapped     = n_wrap;
        case (cw.cell_sel)
            lant_pkg::CELL_LEFT: n_out_word.cell_value = r_left;
            lant_pkg::CELL_RD:   n_out_word.cell_value = r_rd_data;
            default:             n_out_word.cell_value = 1'b0;
        endcase
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= lant_pkg::UC_BOOT_CLR;
            r_ant_row   <= CW'(lant_pkg::fold6(lant_pkg::START_RESET, GRID_SIDE));
            r_ant_col   <= CW'(lant_pkg::fold6(lant_pkg::START_RESET, GRID_SIDE));
            r_heading   <= lant_pkg::HEAD_NORTH;
            r_wrap      <= 1'b0;
            r_start_row <= lant_pkg::START_RESET;
            r_start_col <= lant_pkg::START_RESET;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pc      <= n_pc;
            r_ant_row <= n_ant_row;
            r_ant_col <= n_ant_col;
            r_heading <= n_heading;
            r_wrap    <= n_wrap;

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    lant_pkg::CFG_START_ROW: r_start_row <= i_cfg_data;
                    lant_pkg::CFG_START_COL: r_start_col <= i_cfg_data;
                    default: ;
                endcase
            end

            // sweep address returns to zero at the end of every pass
            if (mem_we && cw.mem == lant_pkg::MEM_WR_CLR) begin
                r_clr_addr <= clr_last ? '0 : r_clr_addr + 1'b1;
            end

            if (step_go && cw.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req_row <= CW'(lant_pkg::fold6(i_in_word.read_row, GRID_SIDE));
            r_req_col <= CW'(lant_pkg::fold6(i_in_word.read_col, GRID_SIDE));
        end
        if (step_go && cw.mem == lant_pkg::MEM_WR_FLIP) begin
            r_left <= ~r_rd_data;
        end
        if (step_go && cw.emit) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // the sweep counter is parked at zero whenever no item is in work
    a_clr_parked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == lant_pkg::UC_IDLE) |-> (r_clr_addr == '0))
        else $error("clear address not parked at idle");

    // an accepted item always leaves the idle step
    a_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_pc != lant_pkg::UC_IDLE))
        else $error("accepted item not dispatched");

    // the ant never leaves the grid
    a_on_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_ant_row) < GRID_SIDE) && (int'(r_ant_col) < GRID_SIDE))
        else $error("ant position off grid");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !(cw.emit && step_go))
        else $error("result overwritten while stalled");

endmodule

FILE: sim/ant_tracker_pkg.sv
// Scoreboard for the Langton's ant stepper: a bit-exact copy of the grid and ant.
// Holds the expected result words in arrival order; compares the block's results.
// Depends on lant_pkg for the word types, opcodes, headings and register indexes.
package ant_tracker_pkg;

    localparam int SIDE = lant_pkg::GRID_SIDE_DEF;

    class ant_tracker;
        bit                  grid [SIDE*SIDE];
        int unsigned         row;
        int unsigned         col;
        logic [1:0]          heading;
        logic [5:0]          start_row;
        logic [5:0]          start_col;
        lant_pkg::t_out_word pending_reports[$];
        int unsigned         mismatches;
        int unsigned         reports_seen;
        int unsigned         words_taken;
        int unsigned         wraps;
        int unsigned         restarts;

        function new();
            foreach (grid[i]) grid[i] = 1'b0;
            start_row = lant_pkg::START_RESET;
            start_col = lant_pkg::START_RESET;
            row = lant_pkg::START_RESET % SIDE;
            col = lant_pkg::START_RESET % SIDE;
            heading = lant_pkg::HEAD_NORTH;
        endfunction

        // new start only lands on the next restart
        function void set_start(logic [lant_pkg::CFG_IDX_W-1:0] idx, logic [5:0] data);
            if (idx == lant_pkg::CFG_START_ROW) begin
                start_row = data;
            end else if (idx == lant_pkg::CFG_START_COL) begin
                start_col = data;
            end
        endfunction

        // move the ant for one accepted word and queue the report it must give
        function void take_item(lant_pkg::t_in_word w);
            lant_pkg::t_out_word r;
            int unsigned idx;
            bit left;
            bit wrap;
            left = 1'b0;
            wrap = 1'b0;
            words_taken++;
            case (w.op)
                lant_pkg::OP_STEP: begin
                    idx = row * SIDE + col;
                    grid[idx] = ~grid[idx];
                    left = grid[idx];
                    case (heading)
                        lant_pkg::HEAD_NORTH: begin
                            if (row == 0) begin
                                row = SIDE - 1;
                                wrap = 1'b1;
                            end else begin
                                row--;
                            end
                        end
                        lant_pkg::HEAD_EAST: begin
                            if (col >= SIDE - 1) begin
                                col = 0;
                                wrap = 1'b1;
                            end else begin
                                col++;
                            end
                        end
                        lant_pkg::HEAD_SOUTH: begin
                            if (row >= SIDE - 1) begin
                                row = 0;
                                wrap = 1'b1;
                            end else begin
                                row++;
                            end
                        end
                        default: begin
                            if (col == 0) begin
                                col = SIDE - 1;
                                wrap = 1'b1;
                            end else begin
                                col--;
                            end
                        end
                    endcase
                    // white: right turn, black: left turn
                    if (grid[row * SIDE + col] == 1'b0) begin
                        heading = heading + 2'd1;
                    end else begin
                        heading = heading - 2'd1;
                    end
                    if (wrap) wraps++;
                end
                lant_pkg::OP_RESTART: begin
                    foreach (grid[i]) grid[i] = 1'b0;
                    row = start_row % SIDE;
                    col = start_col % SIDE;
                    heading = lant_pkg::HEAD_NORTH;
                    restarts++;
                end
                lant_pkg::OP_READ: begin
                    left = grid[(int'(w.read_row) % SIDE) * SIDE + (int'(w.read_col) % SIDE)];
                end
                default: begin
                end
            endcase
            r.ant_row_out = 6'(row);
            r.ant_col_out = 6'(col);
            r.heading_out = heading;
            r.cell_value  = left;
            r.wrapped     = wrap;
            pending_reports.push_back(r);
        endfunction

        function void check_field(string name, logic [5:0] want, logic [5:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void compare_result(lant_pkg::t_out_word got);
            lant_pkg::t_out_word want;
            reports_seen++;
            if (pending_reports.size() == 0) begin
                $error("result word %h arrived with no item outstanding", got);
                mismatches++;
                return;
            end
            want = pending_reports.pop_front();
            check_field("ant_row_out", want.ant_row_out, got.ant_row_out);
            check_field("ant_col_out", want.ant_col_out, got.ant_col_out);
            check_field("heading_out", 6'(want.heading_out), 6'(got.heading_out));
            check_field("cell_value", 6'(want.cell_value), 6'(got.cell_value));
            check_field("wrapped", 6'(want.wrapped), 6'(got.wrapped));
        endfunction
    endclass

endpackage

FILE: sim/tb_top.sv
// Top-level testbench for langtons_ant_stepper_core: directed edge cases, then
// random phases under varied idling. Depends on lant_pkg and ant_tracker_pkg.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED = 2'd3;   // no-op code, still answers
    localparam int WATCHDOG_LIMIT = 20000;      // > reset clear + restart sweep + long hold
    localparam int LONG_HOLD      = 400;        // receiver hold-off stretch
    localparam int SETTLE_CYCLES  = 16;         // generous margin for the sequencer to settle back to idle
    localparam int PHASE_WORDS    = 110;
    localparam int IN_W           = $bits(lant_pkg::t_in_word);
    localparam int SIDE           = ant_tracker_pkg::SIDE;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    lant_pkg::t_in_word   in_word;
    logic                 out_valid;
    logic                 out_stall;
    lant_pkg::t_out_word  out_word;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [lant_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [5:0]           cfg_data;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int hold_cycles        = 0;
    int quiet_cycles       = 0;

    ant_tracker_pkg::ant_tracker tracker = new();

    // 8 ns clock
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    langtons_ant_stepper_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Result side: sample pre-edge values, then pick next cycle's stall.
    // A pending hold-off overrides the random stall until it counts out.
    always @(posedge clk) begin
        if (out_valid && !out_stall) begin
            tracker.compare_result(out_word);
        end
        if (hold_cycles != 0) begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // Watchdog: any handshake on any channel restarts the count.
    // Reset clear and a restart sweep both fit well inside the limit.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic lant_pkg::t_in_word ant_cmd(logic [1:0] op, logic [5:0] r,
                                                   logic [5:0] c);
        lant_pkg::t_in_word w;
        w.op = op;
        w.read_row = r;
        w.read_col = c;
        return w;
    endfunction

    // Mostly steps; reads split between the ant's neighborhood (where black
    // cells live) and anywhere; rare restarts since each costs a full sweep.
    function automatic lant_pkg::t_in_word random_cmd();
        lant_pkg::t_in_word w;
        int unsigned roll;
        w.read_row = 6'($urandom_range(63));
        w.read_col = 6'($urandom_range(63));
        roll = $urandom_range(999);
        if (roll < 8) begin
            w.op = lant_pkg::OP_RESTART;
        end else if (roll < 40) begin
            w.op = OP_UNUSED;
        end else if (roll < 260) begin
            w.op = lant_pkg::OP_READ;
            if (roll < 150) begin
                w.read_row = 6'((int'(tracker.row) + SIDE + $urandom_range(6) - 3) % SIDE);
                w.read_col = 6'((int'(tracker.col) + SIDE + $urandom_range(6) - 3) % SIDE);
            end
        end else begin
            w.op = lant_pkg::OP_STEP;
        end
        return w;
    endfunction

    // Offer one word; random idle cycles first carry junk payload with valid low.
    // Valid is left high on return so back-to-back words need no re-raise.
    task automatic send_cmd(lant_pkg::t_in_word w);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            in_word <= lant_pkg::t_in_word'(IN_W'($urandom));
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        do @(posedge clk); while (in_stall);
        tracker.take_item(w);
    endtask

    // Hold input low until every report is in, then let the sequencer settle
    // back to idle before anything touches the registers.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (tracker.pending_reports.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both start registers back to back, in random order.
    task automatic load_start(logic [5:0] srow, logic [5:0] scol);
        logic [lant_pkg::CFG_IDX_W-1:0] idx [2];
        logic [5:0] val [2];
        if ($urandom_range(1) == 0) begin
            idx[0] = lant_pkg::CFG_START_ROW; val[0] = srow;
            idx[1] = lant_pkg::CFG_START_COL; val[1] = scol;
        end else begin
            idx[0] = lant_pkg::CFG_START_COL; val[0] = scol;
            idx[1] = lant_pkg::CFG_START_ROW; val[1] = srow;
        end
        cfg_valid <= 1'b1;
        for (int i = 0; i < 2; i++) begin
            cfg_index <= idx[i];
            cfg_data <= val[i];
            do @(posedge clk); while (!cfg_ready);
            tracker.set_start(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // One random phase: new start, restart so it lands, then random words.
    task automatic run_phase(logic [5:0] srow, logic [5:0] scol, int idle, int stall,
                             bit long_hold, bit mid_pause);
        drain_results();
        sender_idle_pct = idle;
        receiver_stall_pct <= stall;
        load_start(srow, scol);
        send_cmd(ant_cmd(lant_pkg::OP_RESTART, 6'($urandom_range(63)),
                         6'($urandom_range(63))));
        // receiver goes quiet while the sender keeps pushing: fills the block;
        // starts once the restart sweep is over so the hold-off is not wasted on it
        if (long_hold) begin
            drain_results();
            hold_cycles <= LONG_HOLD;
        end
        for (int i = 0; i < PHASE_WORDS; i++) begin
            if (mid_pause && i == PHASE_WORDS / 2) drain_results();
            send_cmd(random_cmd());
        end
    endtask

    initial begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_word   <= '0;
        out_stall <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= lant_pkg::CFG_START_ROW;
        cfg_data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed ---
        // Registers written right away; the ant must go on from the reset start
        // (32,32) until a restart picks up the new corner.
        load_start(6'd0, 6'd63);
        send_cmd(ant_cmd(lant_pkg::OP_READ, 6'd32, 6'd32));
        send_cmd(ant_cmd(lant_pkg::OP_READ, 6'd0, 6'd0));
        send_cmd(ant_cmd(lant_pkg::OP_READ, 6'd63, 6'd63));
        send_cmd(ant_cmd(OP_UNUSED, 6'd63, 6'd0));
        send_cmd(ant_cmd(lant_pkg::OP_STEP, 6'd0, 6'd0));
        send_cmd(ant_cmd(lant_pkg::OP_READ, 6'd32, 6'd32));      // left black
        send_cmd(ant_cmd(lant_pkg::OP_STEP, 6'd63, 6'd63));
        // From the top-right corner heading north on a clear grid, four steps
        // cross every edge of the grid; the last lands on black and turns left.
        send_cmd(ant_cmd(lant_pkg::OP_RESTART, 6'd0, 6'd0));
        send_cmd(ant_cmd(lant_pkg::OP_READ, 6'd32, 6'd32));      // cleared
        repeat (4) send_cmd(ant_cmd(lant_pkg::OP_STEP, 6'd0, 6'd0));
        send_cmd(ant_cmd(lant_pkg::OP_READ, 6'd0, 6'd63));
        send_cmd(ant_cmd(lant_pkg::OP_READ, 6'd63, 6'd63));
        send_cmd(ant_cmd(lant_pkg::OP_STEP, 6'd63, 6'd63));     // black back to white
        send_cmd(ant_cmd(OP_UNUSED, 6'd0, 6'd0));

        // --- random phases: no idling, sender 86, receiver 86, both 30 ---
        run_phase(6'd0, 6'd0, 0, 0, 1'b1, 1'b0);
        run_phase(6'd63, 6'd63, 86, 0, 1'b0, 1'b0);
        run_phase(6'($urandom_range(63)), 6'($urandom_range(63)), 0, 86, 1'b0, 1'b0);
        run_phase(6'd63, 6'd0, 30, 30, 1'b0, 1'b0);
        run_phase(6'($urandom_range(63)), 6'($urandom_range(63)), 0, 0, 1'b0, 1'b1);

        drain_results();
        $display("Run covered %0d words, %0d restarts and %0d edge wraps over six start",
                 tracker.words_taken, tracker.restarts, tracker.wraps);
        $display("settings; %0d results compared, %0d mismatches.",
                 tracker.reports_seen, tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.pending_reports.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
